>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

>>> hw/rtl/ssfc_pkg.sv
// Package of types, constants and helpers for the sensor scan frame collector.
package ssfc_pkg;

  localparam int MODULES   = 5;
  localparam int WORD_W    = 16;
  localparam int WIDX      = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int BCW       = WIDX + 1;
  localparam int QDEPTH    = 2;
  localparam int QPW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW       = $clog2(QDEPTH + 1);
  localparam int CFG_AW    = 1;
  localparam int CFG_DW    = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] CFG_POLL_COMMAND  = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd6;

  // Input beat modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_TIMEOUT   = 2'd0,
    KIND_UNCHANGED = 2'd1,
    KIND_UPDATE    = 2'd2
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  module_index;
    logic [15:0] module_value;
    logic [15:0] changed_mask;
    logic        send_poll;
    logic        last;
  } out_item_t;

  typedef logic [MODULES-1:0][WORD_W-1:0] frame_t;

  // One event handed from the front to the back
  typedef struct packed {
    logic   is_timeout;
    frame_t words;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Mirror the bit order of a received byte
  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ssfc_front.sv
// Front end: assembles frames from bytes, counts idle ticks, raises events.
module ssfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssfc_pkg::in_item_t in_data,
  input  logic [7:0]        timeout_ticks,
  input  ssfc_pkg::q_stat_t q_stat,
  output logic              push,
  output ssfc_pkg::qent_t   push_data
);

  logic [ssfc_pkg::BCW-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                idle_r, idle_nxt;
  ssfc_pkg::frame_t          frame_r, frame_nxt;
  logic [7:0]                idle_inc;
  logic [7:0]                rev;
  logic [ssfc_pkg::WIDX-1:0] w;
  logic                      accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign rev      = ssfc_pkg::rev8(in_data.rx_byte);
  assign w        = byte_cnt_r[ssfc_pkg::BCW-1:1];
  assign idle_inc = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;

  // Classify the beat and advance the frame state
  always_comb begin
    byte_cnt_nxt         = byte_cnt_r;
    idle_nxt             = idle_r;
    frame_nxt            = frame_r;
    push                 = 1'b0;
    push_data.is_timeout = 1'b0;
    if (accept) begin
      if (in_data.mode == ssfc_pkg::MODE_TICK) begin
        if (idle_inc >= timeout_ticks) begin
          push                 = 1'b1;
          push_data.is_timeout = 1'b1;
          byte_cnt_nxt         = '0;
          idle_nxt             = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        idle_nxt = '0;
        if (byte_cnt_r[0]) begin
          frame_nxt[w][15:8] = rev;
        end else begin
          frame_nxt[w][7:0] = rev;
        end
        if (byte_cnt_r == ssfc_pkg::BCW'(2 * ssfc_pkg::MODULES - 1)) begin
          push         = 1'b1;
          byte_cnt_nxt = '0;
        end else begin
          byte_cnt_nxt = byte_cnt_r + 1'b1;
        end
      end
    end
    push_data.words = frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      idle_r     <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
      idle_r     <= idle_nxt;
    end
  end

  // Frame words need no reset: each half is written before it is read
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

endmodule

>>> hw/rtl/ssfc_queue.sv
// Short event queue between the front end and the result back end.
module ssfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssfc_pkg::qent_t   push_data,
  input  logic              pop,
  output ssfc_pkg::qent_t   head,
  output ssfc_pkg::q_stat_t q_stat
);

  ssfc_pkg::qent_t          ent_r [ssfc_pkg::QDEPTH];
  logic [ssfc_pkg::QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ssfc_pkg::QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ssfc_pkg::QCW-1:0] count_r, count_nxt;
  logic                     do_push, do_pop;

  assign q_stat.full  = (count_r == ssfc_pkg::QCW'(ssfc_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = ent_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ssfc_pkg::QPW'(ssfc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssfc_pkg::QPW'(ssfc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/ssfc_back.sv
// Back end: compares frames with the previous scan and issues result beats.
module ssfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ssfc_pkg::qent_t    head,
  input  ssfc_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               mid_burst,
  output logic               out_valid,
  input  logic               out_ready,
  output ssfc_pkg::out_item_t out_data
);

  ssfc_pkg::frame_t          prev_r, prev_nxt;
  logic [ssfc_pkg::WIDX-1:0] idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ssfc_pkg::out_item_t       out_data_r, res;
  logic                      load, gen, differ, fin;

  assign load      = !out_valid_r || out_ready;
  assign gen       = load && !q_stat.empty;
  assign differ    = |(head.words ^ prev_r);
  assign fin       = (idx_r == ssfc_pkg::WIDX'(ssfc_pkg::MODULES - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mid_burst = (idx_r != '0);

  // Build the next result from the queue head
  always_comb begin
    res          = '0;
    pop          = 1'b0;
    idx_nxt      = idx_r;
    prev_nxt     = prev_r;
    if (head.is_timeout) begin
      res.kind      = ssfc_pkg::KIND_TIMEOUT;
      res.send_poll = 1'b1;
      res.last      = 1'b1;
      pop           = gen;
    end else if ((idx_r == '0) && !differ) begin
      res.kind      = ssfc_pkg::KIND_UNCHANGED;
      res.send_poll = 1'b1;
      res.last      = 1'b1;
      pop           = gen;
    end else begin
      res.kind         = ssfc_pkg::KIND_UPDATE;
      res.module_index = 3'(idx_r);
      res.module_value = head.words[idx_r];
      res.changed_mask = head.words[idx_r] ^ prev_r[idx_r];
      res.send_poll    = fin;
      res.last         = fin;
      if (gen) begin
        prev_nxt[idx_r] = head.words[idx_r];
        pop             = fin;
        idx_nxt         = fin ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      prev_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      out_data_r <= res;
    end
  end

endmodule

>>> hw/rtl/sensor_scan_frame_collector_core.sv
// A result beat turns valid once the final byte's event passes the event queue into the output register.
// The same holds for the tick that times out a frame.
// Throughput: one input beat per cycle while the two-entry event queue has room.
// A changed frame leaves the output register as one beat per module, one per cycle while out_ready holds.
// Reset (rst_n low, synchronous) clears counters, queue, output valid and the previous scan.
// Top level of the sensor scan frame collector: front end, event queue, back end.
`include "assert_macros.svh"

module sensor_scan_frame_collector_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssfc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssfc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ssfc_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [ssfc_pkg::CFG_DW-1:0]     cfg_data
);

  logic [7:0]        timeout_r, timeout_nxt;
  logic              push, pop, mid_burst;
  ssfc_pkg::qent_t   push_data, head;
  ssfc_pkg::q_stat_t q_stat;
  logic              head_frame, single_res;

  // Take configuration writes; the poll byte is not kept by this block
  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_we && (cfg_addr == ssfc_pkg::CFG_TIMEOUT_TICKS)) begin
      timeout_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ssfc_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  ssfc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .timeout_ticks (timeout_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  ssfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  ssfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .mid_burst (mid_burst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign head_frame = !q_stat.empty && !head.is_timeout;
  assign single_res = out_valid && (out_data.kind != ssfc_pkg::KIND_UPDATE);

  // Queue cannot be full and empty at once
  `ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty, "queue full and empty")
  // A burst in progress always has its frame at the queue head
  `ASSERT_CLK(a_mid_has_head, mid_burst |-> head_frame, "burst lost its frame")
  // Single-beat results always close their burst with a poll request
  `ASSERT_CLK(a_single_last, single_res |-> (out_data.last && out_data.send_poll), "single not last")
  // The front never pushes into a full queue
  `ASSERT_NEVER(a_push_full, push && q_stat.full, "push into full queue")

endmodule

>>> tb/sv/sensor_scan_frame_collector_core_test.sv
// Self-checking testbench for the sensor scan frame collector core.
`timescale 1ns / 1ps

module sensor_scan_frame_collector_core_test;
  import ssfc_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_QUOTA    = 14;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_data;

  // Scan model state, kept in step with the block at each accepted beat
  logic [7:0]  poll_byte;
  logic [7:0]  timeout_limit;
  logic [3:0]  scan_bytes_seen;
  logic [7:0]  idle_run;
  logic [15:0] assembled_words [MODULES];
  logic [15:0] last_scan [MODULES];
  logic [15:0] gen_words [MODULES];

  out_item_t awaited_reports [$];
  in_item_t  beats_to_send [$];

  int   beats_queued, beats_accepted, reports_seen, mismatch_count;
  int   timeouts_seen, unchanged_seen, changes_seen, settings_used;
  int   sender_idle_pct, receiver_idle_pct;
  int   stall_cycles;
  logic in_took;

  sensor_scan_frame_collector_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Advance the scan model by one beat and append the results it causes
  function automatic void fold_scan_beat(input in_item_t b);
    logic [7:0] mirrored;
    int         w;
    bit         differ;
    out_item_t  r;
    r = '0;
    if (b.mode == MODE_TICK) begin
      if (idle_run != 8'hFF) idle_run = idle_run + 8'd1;
      if (idle_run >= timeout_limit) begin
        scan_bytes_seen = '0;
        idle_run        = '0;
        r.kind      = KIND_TIMEOUT;
        r.send_poll = 1'b1;
        r.last      = 1'b1;
        awaited_reports.push_back(r);
        timeouts_seen++;
      end
    end else begin
      mirrored = {<<{b.rx_byte}};
      w = int'(scan_bytes_seen >> 1);
      if (w < MODULES) begin
        if (!scan_bytes_seen[0]) assembled_words[w] = {8'h00, mirrored};
        else assembled_words[w] = assembled_words[w] | {mirrored, 8'h00};
      end
      scan_bytes_seen = scan_bytes_seen + 4'd1;
      idle_run        = '0;
      if (scan_bytes_seen >= 2 * MODULES) begin
        scan_bytes_seen = '0;
        differ = 1'b0;
        for (int i = 0; i < MODULES; i++) begin
          if (assembled_words[i] != last_scan[i]) differ = 1'b1;
        end
        if (!differ) begin
          r.kind      = KIND_UNCHANGED;
          r.send_poll = 1'b1;
          r.last      = 1'b1;
          awaited_reports.push_back(r);
          unchanged_seen++;
        end else begin
          // One update per module; only the final one closes the burst
          for (int i = 0; i < MODULES; i++) begin
            r.kind         = KIND_UPDATE;
            r.module_index = 3'(i);
            r.module_value = assembled_words[i];
            r.changed_mask = assembled_words[i] ^ last_scan[i];
            r.send_poll    = (i == MODULES - 1);
            r.last         = (i == MODULES - 1);
            awaited_reports.push_back(r);
            last_scan[i] = assembled_words[i];
          end
          changes_seen++;
        end
      end
    end
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Sample both channels: predict on input beats, check result beats
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        reports_seen++;
        if (awaited_reports.size() == 0) begin
          $error("result beat of kind %0d with none expected", out_data.kind);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_data.kind));
          check_field("module_index", 16'(want.module_index), 16'(out_data.module_index));
          check_field("module_value", want.module_value, out_data.module_value);
          check_field("changed_mask", want.changed_mask, out_data.changed_mask);
          check_field("send_poll", 16'(want.send_poll), 16'(out_data.send_poll));
          check_field("last", 16'(want.last), 16'(out_data.last));
        end
      end
      if (in_valid && in_ready) begin
        fold_scan_beat(in_data);
        beats_accepted++;
      end
    end
  end

  // Present the next queued beat, holding it until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= beats_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Stop the run when work is outstanding and nothing moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (beats_accepted == beats_queued && awaited_reports.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               stall_cycles, awaited_reports.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void queue_beat(input logic mode, input logic [7:0] value);
    in_item_t b;
    b.mode    = mode;
    b.rx_byte = value;
    beats_to_send.push_back(b);
    beats_queued++;
  endfunction

  function automatic void queue_ticks(input int count);
    for (int k = 0; k < count; k++) queue_beat(MODE_TICK, 8'($urandom));
  endfunction

  // Queue one whole frame built from the last one: kept, nudged or fresh
  function automatic int queue_frame(input int tick_pct);
    int         n;
    int         style;
    int         k;
    logic [7:0] half;
    logic [7:0] mirrored;
    n = 0;
    style = $urandom_range(99);
    for (int m = 0; m < MODULES; m++) begin
      if (style >= 70) begin
        gen_words[m] = 16'($urandom);
      end else if (style >= 35 && $urandom_range(1) == 1) begin
        gen_words[m] = gen_words[m] ^ (16'd1 << $urandom_range(15));
      end
      for (int h = 0; h < 2; h++) begin
        if ($urandom_range(99) < tick_pct) begin
          k = $urandom_range(1, 2);
          queue_ticks(k);
          n += k;
        end
        half     = h ? gen_words[m][15:8] : gen_words[m][7:0];
        mirrored = {<<{half}};
        queue_beat(MODE_BYTE, mirrored);
        n++;
      end
    end
    return n;
  endfunction

  // Mostly well-formed frames; some idle runs and abandoned partial frames
  function automatic void random_traffic(input int quota);
    int n;
    int pick;
    int k;
    n = 0;
    while (n < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        n += queue_frame(15);
      end else if (pick < 85) begin
        k = $urandom_range(1, 8);
        queue_ticks(k);
        n += k;
      end else begin
        k = $urandom_range(1, 2 * MODULES - 1);
        repeat (k) queue_beat(MODE_BYTE, 8'($urandom));
        n += k;
        k = (timeout_limit > 8'd8) ? 8 : int'(timeout_limit);
        queue_ticks(k);
        n += k;
      end
    end
  endfunction

  // Wait for every beat to go in and every result to come out, then a little longer
  task automatic settle();
    while (beats_accepted != beats_queued || awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_POLL_COMMAND) poll_byte = value;
    else timeout_limit = value;
  endtask

  // Reconfigure while idle, abandon a partial frame at the new timeout, then randomise
  task automatic run_phase(input logic [7:0] poll, input logic [7:0] limit);
    write_reg(CFG_POLL_COMMAND, poll);
    write_reg(CFG_TIMEOUT_TICKS, limit);
    settings_used++;
    repeat (3) queue_beat(MODE_BYTE, 8'($urandom));
    queue_ticks(int'(limit));
    random_traffic(RANDOM_QUOTA);
    settle();
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    poll_byte       = 8'd133;
    timeout_limit   = TIMEOUT_RESET;
    scan_bytes_seen = '0;
    idle_run        = '0;
    for (int i = 0; i < MODULES; i++) begin
      assembled_words[i] = '0;
      last_scan[i]       = '0;
      gen_words[i]       = '0;
    end
    beats_queued   = 0;
    beats_accepted = 0;
    reports_seen   = 0;
    mismatch_count = 0;
    timeouts_seen  = 0;
    unchanged_seen = 0;
    changes_seen   = 0;
    settings_used  = 1;
    stall_cycles   = 0;
    sender_idle_pct   = 34;
    receiver_idle_pct = 87;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero and full bytes make a changed frame; repeat it with ticks inside, then time out
    for (int k = 0; k < 2 * MODULES; k++) queue_beat(MODE_BYTE, k[0] ? 8'hFF : 8'h00);
    for (int k = 0; k < 2 * MODULES; k++) begin
      if (k == 3 || k == 7) queue_beat(MODE_TICK, 8'hFF);
      queue_beat(MODE_BYTE, k[0] ? 8'hFF : 8'h00);
    end
    queue_ticks(int'(TIMEOUT_RESET));
    settle();

    run_phase(8'h00, 8'd1);
    sender_idle_pct   = 87;
    receiver_idle_pct = 34;
    run_phase(8'hFF, 8'd24);
    // Zero timeout: every tick restarts the frame
    run_phase(8'h5A, 8'd0);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_phase(8'($urandom), 8'($urandom_range(2, 12)));
    run_phase(8'h85, TIMEOUT_RESET);

    $display("Run drove %0d input beats under %0d register settings, %0d result beats seen.",
             beats_accepted, settings_used, reports_seen);
    $display("It predicted %0d timeouts, %0d unchanged frames and %0d changed frames.",
             timeouts_seen, unchanged_seen, changes_seen);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
